/* rtl/uaw_pkg.sv */
`default_nettype none

package uaw_pkg;

   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 32;
   localparam int INDEX_W     = 7;
   localparam int KIND_W      = 2;
   localparam int POS_W       = 9;
   localparam int BLOCK_BYTES = 512;
   localparam int BLOCK_SHIFT = 9;
   localparam int BLK_W       = ADDR_W - BLOCK_SHIFT;

   // Header byte positions
   localparam logic [POS_W-1:0] POS_SIZE_FIRST  = 9'd124;
   localparam logic [POS_W-1:0] POS_SIZE_LAST   = 9'd135;
   localparam logic [POS_W-1:0] POS_TYPE        = 9'd156;
   localparam logic [POS_W-1:0] POS_MAGIC_FIRST = 9'd257;
   localparam logic [POS_W-1:0] POS_MAGIC_LAST  = 9'd261;
   localparam logic [POS_W-1:0] POS_LAST        = 9'd511;

   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_SKIP   = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FILE      = 2'd0,
      KIND_EMPTY     = 2'd1,
      KIND_BAD_MAGIC = 2'd2,
      KIND_FULL      = 2'd3
   } result_kind_type;

   typedef struct packed {
      result_kind_type     kind;
      logic [INDEX_W-1:0]  index;
      logic [ADDR_W-1:0]   address;
      logic [ADDR_W-1:0]   length;
   } result_type;

   // Expected "ustar" character at a magic position
   function automatic logic [BYTE_W-1:0] magic_char(input logic [POS_W-1:0] pos);
      logic [2:0] sel;
      logic [BYTE_W-1:0] ch;
      sel = 3'(pos - POS_MAGIC_FIRST);
      case (sel)
         3'd0:    ch = 8'h75;
         3'd1:    ch = 8'h73;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h61;
         3'd4:    ch = 8'h72;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

/* rtl/uaw_in_reg.sv */
`default_nettype none

module uaw_in_reg (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [uaw_pkg::BYTE_W-1:0] req_archive_byte,
   input  wire logic                       req_restart,
   input  wire logic                       advance,
   output logic                            item_valid,
   output logic [uaw_pkg::BYTE_W-1:0]      item_byte,
   output logic                            item_restart
);

   logic                       valid_ff, valid_in;
   logic [uaw_pkg::BYTE_W-1:0] byte_ff;
   logic                       restart_ff;

   // Hold while the held transaction cannot move on
   assign req_stall = valid_ff & ~advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         byte_ff    <= req_archive_byte;
         restart_ff <= req_restart;
      end
   end

   assign item_valid   = valid_ff;
   assign item_byte    = byte_ff;
   assign item_restart = restart_ff;

endmodule

`default_nettype wire

/* rtl/uaw_walk.sv */
`default_nettype none

module uaw_walk #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic [uaw_pkg::BYTE_W-1:0] arc_byte,
   input  wire logic                       restart,
   input  wire logic [uaw_pkg::ADDR_W-1:0] base_address,
   output logic                            has_result,
   output uaw_pkg::result_type             result
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int BLK_W = uaw_pkg::BLK_W;
   localparam int AW    = uaw_pkg::ADDR_W;

   uaw_pkg::phase_type           phase_ff, phase_in, cur_phase;
   logic [uaw_pkg::POS_W-1:0]    pos_ff, pos_in, cur_pos;
   logic [BLK_W-1:0]             next_block_ff, next_block_in, cur_next_block;
   logic [AW-1:0]                skip_ff, skip_in, cur_skip;
   logic [AW-1:0]                size_ff, size_in, cur_size;
   logic                         open_ff, open_in, cur_open;
   logic [uaw_pkg::BYTE_W-1:0]   type_ff, type_in, cur_type;
   logic                         magic_ff, magic_in, cur_magic;
   logic [CNT_W-1:0]             count_ff, count_in, cur_count;

   logic                         at_start, header_active;
   logic [AW-1:0]                hdr_size, new_size;
   logic                         hdr_open, new_open;
   logic [uaw_pkg::BYTE_W-1:0]   hdr_type, new_type;
   logic                         hdr_magic, new_magic;
   logic                         table_full, empty_name, bad_magic, file_entry;
   logic                         in_size_field, in_magic_field, is_octal;
   logic [BLK_W-1:0]             size_blocks;

   // Restart clears the walk before this byte is looked at
   assign cur_phase      = restart ? uaw_pkg::PHASE_HEADER : phase_ff;
   assign cur_pos        = restart ? '0 : pos_ff;
   assign cur_next_block = restart ? BLK_W'(1) : next_block_ff;
   assign cur_skip       = restart ? '0 : skip_ff;
   assign cur_size       = restart ? '0 : size_ff;
   assign cur_open       = restart ? 1'b1 : open_ff;
   assign cur_type       = restart ? '0 : type_ff;
   assign cur_magic      = restart ? 1'b1 : magic_ff;
   assign cur_count      = restart ? '0 : count_ff;

   // Field decode for the current header byte
   always_comb begin
      header_active  = (cur_phase == uaw_pkg::PHASE_HEADER);
      at_start       = (cur_pos == '0);
      hdr_size       = at_start ? '0 : cur_size;
      hdr_open       = at_start ? 1'b1 : cur_open;
      hdr_type       = at_start ? '0 : cur_type;
      hdr_magic      = at_start ? 1'b1 : cur_magic;
      table_full     = at_start && (cur_count >= CNT_W'(MAX_ENTRIES));
      empty_name     = at_start && (arc_byte == uaw_pkg::CHAR_NUL);
      in_size_field  = (cur_pos >= uaw_pkg::POS_SIZE_FIRST) &&
                       (cur_pos <= uaw_pkg::POS_SIZE_LAST);
      in_magic_field = (cur_pos >= uaw_pkg::POS_MAGIC_FIRST) &&
                       (cur_pos <= uaw_pkg::POS_MAGIC_LAST);
      is_octal       = (arc_byte >= uaw_pkg::CHAR_ZERO) &&
                       (arc_byte <= uaw_pkg::CHAR_SEVEN);

      new_size = hdr_size;
      new_open = hdr_open;
      if (in_size_field) begin
         if (hdr_open && is_octal) begin
            new_size = {hdr_size[AW-4:0], arc_byte[2:0]};
         end else begin
            new_open = 1'b0;
         end
      end
      new_type  = (cur_pos == uaw_pkg::POS_TYPE) ? arc_byte : hdr_type;
      new_magic = hdr_magic &&
                  !(in_magic_field && (arc_byte != uaw_pkg::magic_char(cur_pos)));
      bad_magic  = (cur_pos == uaw_pkg::POS_MAGIC_LAST) && !new_magic;
      file_entry = (cur_pos == uaw_pkg::POS_MAGIC_LAST) && new_magic &&
                   ((new_type == uaw_pkg::CHAR_ZERO) || (new_type == uaw_pkg::CHAR_NUL));
      // Size rounded up to whole blocks
      size_blocks = new_size[AW-1:uaw_pkg::BLOCK_SHIFT] +
                    BLK_W'(|new_size[uaw_pkg::BLOCK_SHIFT-1:0]);
   end

   // Next walk state
   always_comb begin
      phase_in      = cur_phase;
      pos_in        = cur_pos;
      next_block_in = cur_next_block;
      skip_in       = cur_skip;
      size_in       = cur_size;
      open_in       = cur_open;
      type_in       = cur_type;
      magic_in      = cur_magic;
      count_in      = cur_count;
      case (cur_phase)
         uaw_pkg::PHASE_SKIP: begin
            skip_in = cur_skip - AW'(1);
            if (cur_skip == AW'(1)) begin
               phase_in = uaw_pkg::PHASE_HEADER;
               pos_in   = '0;
            end
         end
         uaw_pkg::PHASE_HEADER: begin
            if (table_full || empty_name || bad_magic) begin
               phase_in = uaw_pkg::PHASE_DONE;
            end else begin
               size_in  = new_size;
               open_in  = new_open;
               type_in  = new_type;
               magic_in = new_magic;
               if (file_entry) begin
                  count_in = cur_count + CNT_W'(1);
               end
               if (cur_pos == uaw_pkg::POS_LAST) begin
                  next_block_in = cur_next_block + size_blocks + BLK_W'(1);
                  pos_in        = '0;
                  if (size_blocks != '0) begin
                     skip_in  = {size_blocks, {uaw_pkg::BLOCK_SHIFT{1'b0}}};
                     phase_in = uaw_pkg::PHASE_SKIP;
                  end
               end else begin
                  pos_in = cur_pos + uaw_pkg::POS_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result of this byte
   always_comb begin
      has_result     = 1'b0;
      result.kind    = uaw_pkg::KIND_FILE;
      result.index   = uaw_pkg::INDEX_W'(cur_count);
      result.address = '0;
      result.length  = '0;
      if (header_active) begin
         if (table_full) begin
            has_result  = 1'b1;
            result.kind = uaw_pkg::KIND_FULL;
         end else if (empty_name) begin
            has_result  = 1'b1;
            result.kind = uaw_pkg::KIND_EMPTY;
         end else if (bad_magic) begin
            has_result  = 1'b1;
            result.kind = uaw_pkg::KIND_BAD_MAGIC;
         end else if (file_entry) begin
            has_result     = 1'b1;
            result.address = base_address +
                             {cur_next_block, {uaw_pkg::BLOCK_SHIFT{1'b0}}};
            result.length  = new_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= uaw_pkg::PHASE_HEADER;
         pos_ff        <= '0;
         next_block_ff <= BLK_W'(1);
         skip_ff       <= '0;
         size_ff       <= '0;
         open_ff       <= 1'b1;
         type_ff       <= '0;
         magic_ff      <= 1'b1;
         count_ff      <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         next_block_ff <= next_block_in;
         skip_ff       <= skip_in;
         size_ff       <= size_in;
         open_ff       <= open_in;
         type_ff       <= type_in;
         magic_ff      <= magic_in;
         count_ff      <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/uaw_out_reg.sv */
`default_nettype none

module uaw_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire uaw_pkg::result_type  result,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic                      blocked,
   output uaw_pkg::result_type       held
);

   logic                valid_ff, valid_in;
   uaw_pkg::result_type held_ff;

   assign blocked  = valid_ff & rsp_stall;
   assign valid_in = load | blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign held      = held_ff;

endmodule

`default_nettype wire

/* rtl/ustar_archive_entry_walker.sv */
`default_nettype none
// Tar archive entry walker.
// Feed the archive one byte per req_ transaction (req_archive_byte, with
// req_restart set on the first byte of a new archive). Each regular file
// whose ustar header is seen gives one rsp_ transaction: kind file, its
// index, the address of its data (base plus header offset plus 512) and its
// octal size. The walk ends with one end transaction (empty name, bad magic
// or full table) and then drops bytes until the next restart.
// The csr_ channel writes the base address; write it only while idle.
// A byte is accepted into the input register; its result is loaded into the
// result register, from which rsp_ presents it. Throughput: one byte per
// cycle while no result waits on a stalled rsp_, set by the combinational
// walk update between the two registers.
// A stalled rsp_ transaction holds; bytes that give no result keep flowing,
// and only a byte that would give a result waits, which then stalls req_.
// Reset (synchronous) empties both registers, clears the walk and sets the
// base address to zero.
module ustar_archive_entry_walker #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [uaw_pkg::BYTE_W-1:0]  req_archive_byte,
   input  wire logic                        req_restart,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [uaw_pkg::KIND_W-1:0]       rsp_result_kind,
   output logic [uaw_pkg::INDEX_W-1:0]      rsp_entry_index,
   output logic [uaw_pkg::ADDR_W-1:0]       rsp_data_address,
   output logic [uaw_pkg::ADDR_W-1:0]       rsp_file_length,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [uaw_pkg::ADDR_W-1:0]  csr_base_address
);

   logic [uaw_pkg::ADDR_W-1:0] base_ff;
   logic                       item_valid, item_restart;
   logic [uaw_pkg::BYTE_W-1:0] item_byte;
   logic                       advance, has_result, out_blocked;
   uaw_pkg::result_type        walk_result, held;

   // Base address register: always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         base_ff <= csr_base_address;
      end
   end

   uaw_in_reg u_in (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_archive_byte (req_archive_byte),
      .req_restart      (req_restart),
      .advance          (advance),
      .item_valid       (item_valid),
      .item_byte        (item_byte),
      .item_restart     (item_restart)
   );

   // Advance the held byte unless its result has nowhere to go
   assign advance = item_valid & ~(has_result & out_blocked);

   uaw_walk #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .arc_byte     (item_byte),
      .restart      (item_restart),
      .base_address (base_ff),
      .has_result   (has_result),
      .result       (walk_result)
   );

   uaw_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance & has_result),
      .result    (walk_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .blocked   (out_blocked),
      .held      (held)
   );

   assign rsp_result_kind  = held.kind;
   assign rsp_entry_index  = held.index;
   assign rsp_data_address = held.address;
   assign rsp_file_length  = held.length;

endmodule

`default_nettype wire

/* test/tb_top.sv */
module tb_top;

   // Table depth of the instance; the walk ends with a full-table result
   // once this many regular files have been listed.
   localparam int TABLE_DEPTH = 64;

   // Type flags of interest in a ustar header
   localparam logic [7:0] TYPE_REGULAR     = "0";
   localparam logic [7:0] TYPE_OLD_REGULAR = 8'h00;

   // Magic text at header bytes 257..261, first character in the top byte
   localparam logic [39:0] USTAR_TEXT = "ustar";

   // Header bytes up to and including the last magic character
   localparam int HEADER_CUT = 262;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [uaw_pkg::BYTE_W-1:0] req_archive_byte;
   logic req_restart;
   logic rsp_valid;
   logic rsp_stall;
   logic [uaw_pkg::KIND_W-1:0] rsp_result_kind;
   logic [uaw_pkg::INDEX_W-1:0] rsp_entry_index;
   logic [uaw_pkg::ADDR_W-1:0] rsp_data_address;
   logic [uaw_pkg::ADDR_W-1:0] rsp_file_length;
   logic csr_valid;
   logic csr_ready;
   logic [uaw_pkg::ADDR_W-1:0] csr_base_address;

   ustar_archive_entry_walker #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_archive_byte(req_archive_byte),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_entry_index(rsp_entry_index),
      .rsp_data_address(rsp_data_address),
      .rsp_file_length(rsp_file_length),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_base_address(csr_base_address)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Walk predictor: a private copy of the walk state, advanced once per
   // accepted archive byte. Every result it predicts is queued in order.
   // ------------------------------------------------------------------
   uaw_pkg::phase_type walk_phase;
   logic [uaw_pkg::POS_W-1:0] hdr_pos;
   logic [uaw_pkg::ADDR_W-1:0] hdr_off;
   logic [uaw_pkg::ADDR_W-1:0] skip_left;
   logic [uaw_pkg::ADDR_W-1:0] size_acc;
   logic octal_open;
   logic [7:0] type_seen;
   logic magic_ok;
   logic [uaw_pkg::INDEX_W-1:0] entry_cnt;
   logic [uaw_pkg::ADDR_W-1:0] base_reg;

   uaw_pkg::result_type walk_results_due[$];

   int results_predicted = 0;
   int bytes_sent = 0;
   int fail_count = 0;
   int input_stall_cycles = 0;
   int kinds_checked[4] = '{0, 0, 0, 0};
   int burst_left = 0;

   // Receiver hold-off requests: bump hold_ticket to ask for a hold-off set by hold_len
   int hold_ticket = 0;
   int hold_len = 0;
   int hold_served = 0;
   int hold_left = 0;
   int pattern_left = 0;
   stall_style_type stall_mode = STALL_NONE;

   task automatic clear_walk();
      walk_phase = uaw_pkg::PHASE_HEADER;
      hdr_pos = '0;
      hdr_off = '0;
      skip_left = '0;
      size_acc = '0;
      octal_open = 1'b1;
      type_seen = '0;
      magic_ok = 1'b1;
      entry_cnt = '0;
   endtask

   task automatic queue_walk_result(input uaw_pkg::result_kind_type kind,
                                    input logic [uaw_pkg::INDEX_W-1:0] idx,
                                    input logic [uaw_pkg::ADDR_W-1:0] addr,
                                    input logic [uaw_pkg::ADDR_W-1:0] len);
      uaw_pkg::result_type r;
      r.kind = kind;
      r.index = idx;
      r.address = addr;
      r.length = len;
      walk_results_due.push_back(r);
      results_predicted++;
   endtask

   task automatic walk_archive_byte(input logic [7:0] b, input logic fresh);
      logic [uaw_pkg::POS_W-1:0] p;
      logic [uaw_pkg::ADDR_W-1:0] padded;
      if (fresh) clear_walk();
      // Inside a file body: count down, then expect the next header
      if (walk_phase == uaw_pkg::PHASE_SKIP) begin
         skip_left = skip_left - 1;
         if (skip_left == 0) begin
            walk_phase = uaw_pkg::PHASE_HEADER;
            hdr_pos = '0;
         end
         return;
      end
      if (walk_phase != uaw_pkg::PHASE_HEADER) return;
      p = hdr_pos;
      if (p == 0) begin
         size_acc = '0;
         octal_open = 1'b1;
         type_seen = '0;
         magic_ok = 1'b1;
         // A full table wins over an empty name
         if (entry_cnt >= TABLE_DEPTH) begin
            walk_phase = uaw_pkg::PHASE_DONE;
            queue_walk_result(uaw_pkg::KIND_FULL, entry_cnt, '0, '0);
            return;
         end
         if (b == uaw_pkg::CHAR_NUL) begin
            walk_phase = uaw_pkg::PHASE_DONE;
            queue_walk_result(uaw_pkg::KIND_EMPTY, entry_cnt, '0, '0);
            return;
         end
      end
      // Size field: accumulate octal digits until the first other byte
      if (p >= uaw_pkg::POS_SIZE_FIRST && p <= uaw_pkg::POS_SIZE_LAST) begin
         if (octal_open && b >= uaw_pkg::CHAR_ZERO && b <= uaw_pkg::CHAR_SEVEN)
            size_acc = {size_acc[uaw_pkg::ADDR_W-4:0], 3'b000} +
                       uaw_pkg::ADDR_W'(b - uaw_pkg::CHAR_ZERO);
         else
            octal_open = 1'b0;
      end
      if (p == uaw_pkg::POS_TYPE) type_seen = b;
      if (p >= uaw_pkg::POS_MAGIC_FIRST && p <= uaw_pkg::POS_MAGIC_LAST) begin
         if (b != USTAR_TEXT[8 * (uaw_pkg::POS_MAGIC_LAST - p) +: 8]) magic_ok = 1'b0;
         if (p == uaw_pkg::POS_MAGIC_LAST) begin
            if (!magic_ok) begin
               walk_phase = uaw_pkg::PHASE_DONE;
               queue_walk_result(uaw_pkg::KIND_BAD_MAGIC, entry_cnt, '0, '0);
               return;
            end
            if (type_seen == TYPE_REGULAR || type_seen == TYPE_OLD_REGULAR) begin
               queue_walk_result(uaw_pkg::KIND_FILE, entry_cnt,
                                 base_reg + hdr_off +
                                 uaw_pkg::ADDR_W'(uaw_pkg::BLOCK_BYTES),
                                 size_acc);
               entry_cnt++;
            end
         end
      end
      // End of header: round the size up to whole blocks (wrapping) and skip it
      if (p == uaw_pkg::POS_LAST) begin
         padded = size_acc + uaw_pkg::ADDR_W'(uaw_pkg::POS_LAST);
         padded[uaw_pkg::BLOCK_SHIFT-1:0] = '0;
         hdr_off = hdr_off + uaw_pkg::ADDR_W'(uaw_pkg::BLOCK_BYTES) + padded;
         hdr_pos = '0;
         if (padded != 0) begin
            skip_left = padded;
            walk_phase = uaw_pkg::PHASE_SKIP;
         end
      end else begin
         hdr_pos = p + 1'b1;
      end
   endtask

   // ------------------------------------------------------------------
   // Byte sender: bursts of random length with random gaps in between.
   // Returns at the edge where the transaction is accepted.
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic fresh);
      int gap;
      if (burst_left == 0) begin
         // Mostly short bursts, now and then a long unbroken run
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_archive_byte <= b;
      req_restart <= fresh;
      do @(posedge clock); while (req_stall);
      walk_archive_byte(b, fresh);
      burst_left--;
      bytes_sent++;
   endtask

   // Text of an 11-digit octal size field closed by a NUL, first char on top
   function automatic logic [95:0] octal_text(input logic [31:0] v);
      logic [95:0] t;
      logic [32:0] w;
      w = {1'b0, v};
      for (int k = 0; k < 11; k++)
         t[95 - 8 * k -: 8] = uaw_pkg::CHAR_ZERO + 8'(w[3 * (10 - k) +: 3]);
      t[7:0] = uaw_pkg::CHAR_NUL;
      return t;
   endfunction

   // Send the first cut bytes of one header; stop early once the walk ends
   task automatic send_header(input logic [7:0] name0, input logic [95:0] size_text,
                              input logic [7:0] type_byte, input logic [39:0] magic,
                              input bit fresh, input int cut);
      logic [7:0] b;
      for (int p = 0; p < cut; p++) begin
         if (p == 0)
            b = name0;
         else if (p >= uaw_pkg::POS_SIZE_FIRST && p <= uaw_pkg::POS_SIZE_LAST)
            b = size_text[95 - 8 * (p - uaw_pkg::POS_SIZE_FIRST) -: 8];
         else if (p == uaw_pkg::POS_TYPE)
            b = type_byte;
         else if (p >= uaw_pkg::POS_MAGIC_FIRST && p <= uaw_pkg::POS_MAGIC_LAST)
            b = magic[39 - 8 * (p - uaw_pkg::POS_MAGIC_FIRST) -: 8];
         else
            b = 8'($urandom);
         send_byte(b, fresh && p == 0);
         if (walk_phase == uaw_pkg::PHASE_DONE) break;
      end
   endtask

   task automatic send_ignored(input int count);
      for (int n = 0; n < count; n++)
         send_byte(8'($urandom), 1'b0);
   endtask

   // Drop valid and let every pending result drain, then allow time for a
   // byte still in flight that gives no result
   task automatic settle_walk();
      req_valid <= 1'b0;
      while (walk_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_base_address(input logic [uaw_pkg::ADDR_W-1:0] addr);
      settle_walk();
      csr_valid <= 1'b1;
      csr_base_address <= addr;
      do @(posedge clock); while (!csr_ready);
      base_reg = addr;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Test tasks
   // ------------------------------------------------------------------

   // Restart on every byte: a NUL name ends the walk at once, so end results
   // come back to back; a named restart just opens a new header
   task automatic test_empty_names();
      logic [7:0] b;
      for (int n = 0; n < 24; n++) begin
         b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : uaw_pkg::CHAR_NUL;
         send_byte(b, 1'b1);
      end
      send_byte(uaw_pkg::CHAR_NUL, 1'b1);
      // Bytes after the end are dropped until the next restart
      send_ignored(6);
   endtask

   // One regular file header up to its magic; the size field takes one of
   // several forms
   task automatic test_file_entry();
      logic [95:0] size_text;
      logic [7:0] type_byte;
      int pick;
      write_base_address($urandom);
      pick = $urandom_range(0, 3);
      case (pick)
         0: size_text = octal_text($urandom);
         // Twelve digits wrap past 32 bits
         1: size_text = "777777777777";
         // A non-octal digit in the middle stops the parse
         2: size_text = {"0000012", "8", "7770"};
         // Leading space ends the digit run at once: size zero
         default: size_text = {" ", "0000001000", uaw_pkg::CHAR_NUL};
      endcase
      type_byte = ($urandom_range(0, 1) != 0) ? TYPE_REGULAR : TYPE_OLD_REGULAR;
      send_header(8'($urandom_range(1, 255)), size_text, type_byte, USTAR_TEXT,
                  1'b1, HEADER_CUT);
   endtask

   // One header with a single broken magic character ends the walk
   task automatic test_bad_magic();
      logic [39:0] magic;
      int k;
      magic = USTAR_TEXT;
      k = $urandom_range(0, 4);
      magic[39 - 8 * k -: 8] = magic[39 - 8 * k -: 8] ^ 8'($urandom_range(1, 255));
      send_header(8'($urandom_range(1, 255)), octal_text($urandom_range(0, 900)),
                  TYPE_REGULAR, magic, 1'b1, HEADER_CUT);
      send_ignored($urandom_range(2, 8));
   endtask

   // Hold the result side off for a long stretch while restarts on empty
   // names keep coming, so results pile up and the block stalls its input
   task automatic test_backpressure();
      settle_walk();
      hold_len = 150;
      hold_ticket++;
      for (int n = 0; n < 24; n++)
         send_byte(uaw_pkg::CHAR_NUL, 1'b1);
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   // Stall on a pattern that changes at random intervals; serve a
   // requested hold-off first
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left = hold_len;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_mode = stall_style_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 120);
         end
         pattern_left--;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_stall <= (pattern_left % 5 < 2);
            default:        rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic report_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, what, want, got);
      end
   endtask

   // Compare every accepted result transaction with the oldest prediction
   always @(posedge clock) begin
      uaw_pkg::result_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (walk_results_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual kind %0d index %0d",
                        $time, rsp_result_kind, rsp_entry_index);
            end else begin
               want = walk_results_due.pop_front();
               report_field("result kind", 32'(want.kind), 32'(rsp_result_kind));
               report_field("entry index", 32'(want.index), 32'(rsp_entry_index));
               report_field("data address", want.address, rsp_data_address);
               report_field("file length", want.length, rsp_file_length);
               kinds_checked[want.kind]++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_archive_byte <= '0;
      req_restart <= 1'b0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_base_address <= '0;
      clear_walk();
      base_reg = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_names();
      test_file_entry();
      test_bad_magic();
      test_backpressure();

      // Drain whatever is still in flight
      settle_walk();

      $display("Walked %0d archive bytes: %0d file entries, %0d empty-name ends,",
               bytes_sent, kinds_checked[uaw_pkg::KIND_FILE],
               kinds_checked[uaw_pkg::KIND_EMPTY]);
      $display("%0d bad-magic ends; input held back %0d cycles",
               kinds_checked[uaw_pkg::KIND_BAD_MAGIC], input_stall_cycles);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #2400000;
      $display("Timeout with %0d results outstanding", walk_results_due.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
